/* hw/rtl/node_command_transactor_core_defines.svh */
// Assertion helpers shared by the transactor RTL.
`ifndef NODE_COMMAND_TRANSACTOR_CORE_DEFINES_SVH
`define NODE_COMMAND_TRANSACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("transactor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("transactor assertion failed");

`endif

/* hw/rtl/nct_pkg.sv */
`default_nettype none

package nct_pkg;

    localparam int NODE_BITS = 6;
    localparam logic [NODE_BITS-1:0] NODE_BROADCAST = {NODE_BITS{1'b1}};

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int S_DATA_BITS    = 32;
    localparam int S_USER_BITS    = 2;
    localparam int M_DATA_BITS    = 24;
    localparam int M_USER_BITS    = 1;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLUSH_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLY_TIMEOUT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_GAP     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_ENABLE   = 3'd4;

    localparam logic [15:0] FLUSH_TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd20000;
    localparam logic [15:0] RETRY_GAP_RESET     = 16'd20000;
    localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd10;
    localparam logic [63:0] NODE_ENABLE_RESET   = 64'hFFFF_FFFF_FFFF_FFFE;

    // Request kinds
    localparam logic [1:0] REQ_COMMAND = 2'd0;
    localparam logic [1:0] REQ_RX_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    // Result kinds
    localparam logic KIND_TRANSMIT = 1'b0;
    localparam logic KIND_FINISH   = 1'b1;

    // Finish status codes
    localparam logic [1:0] STATUS_ANSWERED  = 2'd0;
    localparam logic [1:0] STATUS_BROADCAST = 2'd1;
    localparam logic [1:0] STATUS_DISABLED  = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT   = 2'd3;

    localparam logic [6:0]  NO_POSITION = 7'd100;
    localparam logic [7:0]  FRAME_HEAD  = 8'hA5;
    localparam logic [7:0]  FRAME_TAIL  = 8'hFF;
    localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

    // Result slots of one burst: five frame bytes, then the finish report
    localparam logic [2:0] SLOT_HEAD   = 3'd0;
    localparam logic [2:0] SLOT_ADDR   = 3'd1;
    localparam logic [2:0] SLOT_FIRST  = 3'd2;
    localparam logic [2:0] SLOT_SECOND = 3'd3;
    localparam logic [2:0] SLOT_TAIL   = 3'd4;
    localparam logic [2:0] SLOT_FINISH = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_FLUSH = 5'b00010,
        PH_NODE  = 5'b00100,
        PH_POS   = 5'b01000,
        PH_GAP   = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

/* hw/rtl/node_command_transactor_core.sv */
// Result path: the first result of a transaction is registered in the burst register at
// the accepting edge, then in the output register, which drives m_, once that is free.
// Throughput: one input transaction per cycle while each causes at most one result and
// the result stream is not stalled; results leave one per cycle while m_tready is high,
// so a frame burst (five or six results) holds s_tready low until its last result moves
// into the output register. Reset: synchronous, active-low aresetn; control state and
// configuration registers take their documented reset values, no result is pending.
`default_nettype none

`include "node_command_transactor_core_defines.svh"

module node_command_transactor_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [nct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [nct_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // command_code[1:0], target_node[7:2], payload_first[15:8],
    // payload_second[23:16], received_byte[31:24]
    input  wire logic [nct_pkg::S_DATA_BITS-1:0]       s_tdata,
    // req_type[1:0]
    input  wire logic [nct_pkg::S_USER_BITS-1:0]       s_tuser,
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // transmit_byte[7:0], finish_status[9:8], attempts_used[13:10],
    // reported_position[20:14], zero[23:21]
    output logic [nct_pkg::M_DATA_BITS-1:0]            m_tdata,
    // result_kind[0]
    output logic [nct_pkg::M_USER_BITS-1:0]            m_tuser,
    output logic                                       m_tlast
);
    import nct_pkg::*;

    // configuration
    logic [15:0] flush_timeout_reg;
    logic [15:0] reply_timeout_reg;
    logic [15:0] retry_gap_reg;
    logic [3:0]  retry_limit_reg;
    logic [63:0] node_enable_reg;

    // transaction state
    phase_t               phase_reg, phase_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic [7:0]           first_reg, first_next;
    logic [7:0]           second_reg, second_next;
    logic [15:0]          wait_reg, wait_next;
    logic [3:0]           attempt_reg, attempt_next;
    logic [NODE_BITS-1:0] echo_reg, echo_next;
    logic [6:0]           pos_reg, pos_next;

    // input fields
    logic [1:0]           in_req;
    logic [1:0]           in_cmd;
    logic [NODE_BITS-1:0] in_node;
    logic [7:0]           in_first;
    logic [7:0]           in_second;
    logic [7:0]           in_rx;

    logic        s_fire;
    logic        go_start, go_frame, go_fail, go_endgap, go_finish;
    logic [1:0]  fin_status;
    logic [6:0]  fin_pos;
    logic [15:0] wait_inc;
    logic [3:0]  limit_eff;

    // burst register
    logic       b_valid_reg;
    logic       b_finish_reg;
    logic [2:0] b_slot_reg;
    logic [7:0] b_addr_reg, b_first_reg, b_second_reg;
    logic [1:0] b_status_reg;
    logic [3:0] b_attempt_reg;
    logic [6:0] b_pos_reg;
    logic       b_last;
    logic       b_move;
    logic       b_done;
    logic [7:0] b_byte;
    logic       b_kind;

    // output register
    logic       o_valid_reg;
    logic       o_kind_reg;
    logic [7:0] o_byte_reg;
    logic [1:0] o_status_reg;
    logic [3:0] o_attempt_reg;
    logic [6:0] o_pos_reg;
    logic       o_last_reg;
    logic       o_free;

    assign in_req    = s_tuser;
    assign in_cmd    = s_tdata[1:0];
    assign in_node   = s_tdata[2 +: NODE_BITS];
    assign in_first  = s_tdata[15:8];
    assign in_second = s_tdata[23:16];
    assign in_rx     = s_tdata[31:24];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_timeout_reg <= FLUSH_TIMEOUT_RESET;
            reply_timeout_reg <= REPLY_TIMEOUT_RESET;
            retry_gap_reg     <= RETRY_GAP_RESET;
            retry_limit_reg   <= RETRY_LIMIT_RESET;
            node_enable_reg   <= NODE_ENABLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FLUSH_TIMEOUT: flush_timeout_reg <= cfg_data[15:0];
                CFG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data[15:0];
                CFG_RETRY_GAP:     retry_gap_reg     <= cfg_data[15:0];
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[3:0];
                CFG_NODE_ENABLE:   node_enable_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign wait_inc  = (wait_reg != WAIT_MAX) ? wait_reg + 16'd1 : wait_reg;
    assign limit_eff = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;

    // Next state for one transaction: decode the request, then resolve the chain
    // fail -> end of gap -> new attempt -> frame in that order.
    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        node_next    = node_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        wait_next    = wait_reg;
        attempt_next = attempt_reg;
        echo_next    = echo_reg;
        pos_next     = pos_reg;
        go_start     = 1'b0;
        go_frame     = 1'b0;
        go_fail      = 1'b0;
        go_endgap    = 1'b0;
        go_finish    = 1'b0;
        fin_status   = STATUS_ANSWERED;
        fin_pos      = NO_POSITION;

        case (in_req)
            REQ_COMMAND: begin
                if (phase_reg == PH_IDLE) begin
                    cmd_next     = in_cmd;
                    node_next    = in_node;
                    first_next   = in_first;
                    second_next  = in_second;
                    attempt_next = 4'd0;
                    pos_next     = NO_POSITION;
                    echo_next    = '0;
                    wait_next    = 16'd0;
                    if (!node_enable_reg[in_node]) begin
                        go_finish  = 1'b1;
                        fin_status = STATUS_DISABLED;
                        fin_pos    = NO_POSITION;
                    end else begin
                        go_start = 1'b1;
                    end
                end
            end
            REQ_RX_BYTE: begin
                unique case (phase_reg)
                    PH_FLUSH: go_frame = 1'b1;
                    PH_NODE: begin
                        echo_next  = in_rx[NODE_BITS-1:0];
                        wait_next  = 16'd0;
                        phase_next = PH_POS;
                    end
                    PH_POS: begin
                        if (in_rx < 8'(NO_POSITION)) begin
                            pos_next = in_rx[6:0];
                        end
                        if (echo_reg == node_reg) begin
                            go_finish  = 1'b1;
                            fin_status = STATUS_ANSWERED;
                            fin_pos    = pos_next;
                        end else begin
                            go_fail = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                unique case (phase_reg)
                    PH_FLUSH: begin
                        wait_next = wait_inc;
                        go_frame  = (wait_inc >= flush_timeout_reg);
                    end
                    PH_NODE, PH_POS: begin
                        wait_next = wait_inc;
                        go_fail   = (wait_inc >= reply_timeout_reg);
                    end
                    PH_GAP: begin
                        wait_next = wait_inc;
                        go_endgap = (wait_inc >= retry_gap_reg);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (go_fail) begin
            wait_next  = 16'd0;
            phase_next = PH_GAP;
            if (retry_gap_reg == 16'd0) begin
                go_endgap = 1'b1;
            end
        end

        if (go_endgap) begin
            if (attempt_next >= limit_eff) begin
                go_finish  = 1'b1;
                fin_status = STATUS_TIMEOUT;
                fin_pos    = pos_next;
            end else begin
                go_start = 1'b1;
            end
        end

        if (go_start) begin
            pos_next  = NO_POSITION;
            echo_next = '0;
            wait_next = 16'd0;
            if (flush_timeout_reg == 16'd0) begin
                go_frame = 1'b1;
            end else begin
                phase_next = PH_FLUSH;
            end
        end

        if (go_frame) begin
            attempt_next = attempt_next + 4'd1;
            wait_next    = 16'd0;
            if (node_next == NODE_BROADCAST) begin
                go_finish  = 1'b1;
                fin_status = STATUS_BROADCAST;
                fin_pos    = pos_next;
            end else begin
                phase_next = PH_NODE;
            end
        end

        if (go_finish) begin
            phase_next = PH_IDLE;
        end
    end

    // Burst to output register handoff
    assign o_free   = !o_valid_reg || m_tready;
    assign b_last   = (b_slot_reg == SLOT_FINISH) || ((b_slot_reg == SLOT_TAIL) && !b_finish_reg);
    assign b_move   = b_valid_reg && o_free;
    assign b_done   = b_move && b_last;
    assign s_tready = !b_valid_reg || b_done;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        case (b_slot_reg)
            SLOT_HEAD:   b_byte = FRAME_HEAD;
            SLOT_ADDR:   b_byte = b_addr_reg;
            SLOT_FIRST:  b_byte = b_first_reg;
            SLOT_SECOND: b_byte = b_second_reg;
            SLOT_TAIL:   b_byte = FRAME_TAIL;
            default:     b_byte = 8'd0;
        endcase
    end
    assign b_kind = (b_slot_reg == SLOT_FINISH) ? KIND_FINISH : KIND_TRANSMIT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cmd_reg     <= '0;
            node_reg    <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
            wait_reg    <= '0;
            attempt_reg <= '0;
            echo_reg    <= '0;
            pos_reg     <= NO_POSITION;
        end else if (s_fire) begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            node_reg    <= node_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            wait_reg    <= wait_next;
            attempt_reg <= attempt_next;
            echo_reg    <= echo_next;
            pos_reg     <= pos_next;
        end
    end

    // Load a new burst, or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_slot_reg  <= SLOT_HEAD;
        end else if (s_fire && (go_frame || go_finish)) begin
            b_valid_reg <= 1'b1;
            b_slot_reg  <= go_frame ? SLOT_HEAD : SLOT_FINISH;
        end else if (b_done) begin
            b_valid_reg <= 1'b0;
        end else if (b_move) begin
            b_slot_reg <= b_slot_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (go_frame || go_finish)) begin
            b_finish_reg  <= go_finish;
            b_addr_reg    <= (8'(cmd_next) << 6) | 8'(node_next);
            b_first_reg   <= first_next;
            b_second_reg  <= second_next;
            b_status_reg  <= fin_status;
            b_attempt_reg <= attempt_next;
            b_pos_reg     <= fin_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_free) begin
            o_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            o_kind_reg    <= b_kind;
            o_byte_reg    <= b_byte;
            o_status_reg  <= (b_kind == KIND_FINISH) ? b_status_reg : 2'd0;
            o_attempt_reg <= (b_kind == KIND_FINISH) ? b_attempt_reg : 4'd0;
            o_pos_reg     <= (b_kind == KIND_FINISH) ? b_pos_reg : 7'd0;
            o_last_reg    <= b_last;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'd0, o_pos_reg, o_attempt_reg, o_status_reg, o_byte_reg};

    `NCT_ASSERT_IMP(a_no_broadcast_reply_wait, aclk, aresetn,
        (phase_reg == PH_NODE) || (phase_reg == PH_POS), node_reg != NODE_BROADCAST)
    `NCT_ASSERT_IMP(a_burst_not_empty, aclk, aresetn,
        b_valid_reg, b_finish_reg || (b_slot_reg != SLOT_FINISH))
    `NCT_ASSERT_IMP(a_position_in_range, aclk, aresetn,
        o_valid_reg, o_pos_reg <= NO_POSITION)
    `NCT_ASSERT_NEXT(a_result_follows_burst, aclk, aresetn,
        b_valid_reg && o_free, o_valid_reg)

endmodule

`default_nettype wire
